// File: hdl/fcsg_pkg.sv
package fcsg_pkg;

    localparam int COORD_BITS = 12;
    localparam int RADIUS_BITS = 6;
    localparam int OUT_BITS = 13;
    localparam int MAX_RADIUS = 63;
    localparam int MAX_STEPS = 48;

    localparam int IN_DATA_BITS = 32;
    localparam int OUT_DATA_BITS = 104;

    // Offsets i and j, signed so that a comparison never wraps.
    localparam int OFS_BITS = 8;
    // Squares of offsets up to MAX_RADIUS, room for a sum of two, plus a sign bit.
    localparam int SQ_BITS = 14;
    localparam int CNT_BITS = 6;

    localparam int PC_BITS = 1;
    typedef logic [PC_BITS-1:0] pc_t;

    // Program addresses.
    localparam pc_t PC_IDLE = 1'b0;
    localparam pc_t PC_STEP = 1'b1;

    typedef enum logic [0:0] {
        COND_NO_INPUT,
        COND_MORE_WORK
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  run_step;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    // Control store. The program counter advances by one unless the condition holds,
    // in which case it jumps to the target.
    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        unique case (pc)
            PC_IDLE: w = '{take_in: 1'b1, run_step: 1'b0, cond: COND_NO_INPUT, target: PC_IDLE};
            PC_STEP: w = '{take_in: 1'b0, run_step: 1'b1, cond: COND_MORE_WORK, target: PC_STEP};
            default: w = '{take_in: 1'b0, run_step: 1'b0, cond: COND_NO_INPUT, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/filled_circle_span_generator_top.sv
// Channel   Direction  Payload
// s_axis    in         tdata: center_x[11:0], center_y[23:12], radius[29:24], zero pad
// m_axis    out        tdata: near_left, near_right, near_row_low, near_row_high,
//                      wide_left, wide_right, wide_row_low, wide_row_high (13 bits each);
//                      tlast: last_step
//
// A circle request is taken, and then one result is produced per cycle, while m_axis
// does not hold it back, by a single step datapath, so a circle of radius r gives about
// r/sqrt(2)+1 results (46 for radius 63, never more than 48).
// The output register lets the next request be taken while the last result waits.
// Back-pressure on m_axis holds the sequencer on its step word without loss.
// Reset clears the program counter and the output valid flag asynchronously.
module filled_circle_span_generator_top
    import fcsg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // center_x [11:0], center_y [23:12], radius [29:24], zeros [31:30]
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // near_left, near_right, near_row_low, near_row_high, wide_left, wide_right,
    // wide_row_low, wide_row_high, 13 bits each from the lowest bit up
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // last_step
    output logic                     m_axis_tlast
);

    // Sequencer state.
    pc_t        pc_reg, pc_next;
    ctrl_word_t cw;

    // Circle registers.
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic signed [OFS_BITS-1:0]   i_reg, i_next;
    logic signed [OFS_BITS-1:0]   j_reg, j_next;
    logic signed [SQ_BITS-1:0]    sj_reg, sj_next;   // j*j
    logic signed [SQ_BITS-1:0]    si_reg, si_next;   // i*i
    logic signed [SQ_BITS-1:0]    rr_reg, rr_next;   // r*r
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    // Step datapath.
    logic                          accept;
    logic                          slot_free;
    logic                          step_fire;
    logic signed [SQ_BITS-1:0]     f_val;
    logic                          dec;
    logic signed [OFS_BITS-1:0]    i_new;
    logic                          last;
    logic                          cond_hit;
    logic [RADIUS_BITS-1:0]        in_r;
    logic [2*RADIUS_BITS-1:0]      in_rr;
    logic signed [OUT_BITS-1:0]    xe, ye, ie, je;

    assign cw = rom_word(pc_reg);

    assign s_axis_tready = cw.take_in;
    assign accept        = s_axis_tvalid && cw.take_in;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign step_fire     = cw.run_step && slot_free;

    assign in_r  = s_axis_tdata[2*COORD_BITS +: RADIUS_BITS];
    assign in_rr = in_r * in_r;

    // Decide whether the row offset drops in this step.
    assign f_val = sj_reg + si_reg - rr_reg;
    assign dec   = f_val > 0;
    assign i_new = dec ? i_reg - OFS_BITS'(1) : i_reg;
    assign last  = (i_new <= j_reg) || (cnt_reg == CNT_BITS'(MAX_STEPS - 1));

    assign xe = OUT_BITS'(x_reg);
    assign ye = OUT_BITS'(y_reg);
    assign ie = OUT_BITS'(i_new);
    assign je = OUT_BITS'(j_reg);

    always_comb
    begin
        unique case (cw.cond)
            COND_NO_INPUT:  cond_hit = !accept;
            COND_MORE_WORK: cond_hit = !(step_fire && last);
            default:        cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? cw.target : pc_reg + PC_BITS'(1);
    end

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        sj_next  = sj_reg;
        si_next  = si_reg;
        rr_next  = rr_reg;
        cnt_next = cnt_reg;

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (accept)
        begin
            x_next   = s_axis_tdata[0 +: COORD_BITS];
            y_next   = s_axis_tdata[COORD_BITS +: COORD_BITS];
            i_next   = OFS_BITS'(in_r);
            j_next   = '0;
            sj_next  = '0;
            si_next  = SQ_BITS'(in_rr);
            rr_next  = SQ_BITS'(in_rr);
            cnt_next = '0;
        end

        if (step_fire)
        begin
            // Squares are kept up to date by differences: (a-1)^2 = a^2 - 2a + 1.
            if (dec)
            begin
                i_next  = i_new;
                si_next = si_reg - SQ_BITS'({i_reg, 1'b0}) + SQ_BITS'(1);
            end
            j_next   = j_reg + OFS_BITS'(1);
            sj_next  = sj_reg + SQ_BITS'({j_reg, 1'b0}) + SQ_BITS'(1);
            cnt_next = cnt_reg + CNT_BITS'(1);

            out_valid_next = 1'b1;
            out_last_next  = last;
            out_data_next  = {OUT_BITS'(ye - je), OUT_BITS'(ye + je),
                              OUT_BITS'(xe + ie), OUT_BITS'(xe - ie),
                              OUT_BITS'(ye - ie), OUT_BITS'(ye + ie),
                              OUT_BITS'(xe + je), OUT_BITS'(xe - je)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        sj_reg       <= sj_next;
        si_reg       <= si_next;
        rr_reg       <= rr_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // A taken request always starts the step word.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> pc_reg == PC_STEP)
        else $error("request taken but sequencer not stepping");

    // A pending result that is not the last one means the run is still going.
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> pc_reg == PC_STEP)
        else $error("run closed before its last result");

    // While stepping, the row offset never falls below the column.
    a_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == PC_STEP |-> i_reg >= j_reg)
        else $error("row offset below column during a run");

    // The step count stays within the hard bound.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == PC_STEP |-> cnt_reg <= CNT_BITS'(MAX_STEPS - 1))
        else $error("step count past its bound");

endmodule
